// ===== sv/tvmp_pkg.sv =====
`timescale 1ns / 1ps

package tvmp_pkg;

	// fixed field widths
	localparam int unsigned BYTE_BITS      = 8;
	localparam int unsigned FIELD_TAG_BITS = 20;
	localparam int unsigned CFG_BITS       = 20;
	localparam int unsigned CHECK_BITS     = 10;
	localparam int unsigned REG_IDX_BITS   = 1;

	// character codes
	localparam logic [BYTE_BITS-1:0] SEP_BYTE   = 8'h3D;
	localparam logic [BYTE_BITS-1:0] DIGIT_ZERO = 8'h30;
	localparam logic [BYTE_BITS-1:0] DIGIT_NINE = 8'h39;

	// checksum value saturates here, a value no byte sum can reach
	localparam logic [CHECK_BITS-1:0] CHECK_MAX = 10'd1023;

	// register reset values
	localparam logic [BYTE_BITS-1:0]      DELIM_RESET        = 8'h01;
	localparam logic [FIELD_TAG_BITS-1:0] CHECKSUM_TAG_RESET = 20'd10;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FIELD_DELIM  = 1'b0,
		REG_CHECKSUM_TAG = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_TAG   = 2'd0,
		KIND_SEP   = 2'd1,
		KIND_VALUE = 2'd2,
		KIND_DELIM = 2'd3
	} byte_kind_t;

	// per-message parser state, tag accumulator kept apart (parameter width)
	typedef struct packed {
		logic                  in_value;
		logic                  tag_digit_seen;
		logic                  tag_digits_closed;
		logic                  tag_overflow;
		logic [BYTE_BITS-1:0]  running_sum;
		logic [BYTE_BITS-1:0]  field_start_sum;
		logic                  check_field_active;
		logic [CHECK_BITS-1:0] check_value_accum;
		logic                  check_digits_closed;
		logic                  check_seen;
		logic [BYTE_BITS-1:0]  check_region_sum;
		logic [CHECK_BITS-1:0] check_expected;
	} msg_state_t;

	// one result word
	typedef struct packed {
		byte_kind_t              kind;
		logic [BYTE_BITS-1:0]    data;
		logic [FIELD_TAG_BITS-1:0] field_tag;
		logic                    tag_ok;
		logic                    field_end;
		logic                    msg_end;
		logic                    msg_ok;
	} result_t;

endpackage

// ===== sv/tvmp_tag_acc.sv =====
`timescale 1ns / 1ps

module tvmp_tag_acc import tvmp_pkg::*; #(
	parameter int unsigned TAG_BITS = 20
) (
	input  logic [TAG_BITS-1:0] accum,
	input  logic [3:0]          digit,
	output logic [TAG_BITS-1:0] accum_next,
	output logic                overflow
);

	localparam int unsigned PROD_BITS = TAG_BITS + 4;

	logic [PROD_BITS-1:0] acc_wide;
	logic [PROD_BITS-1:0] prod;

	// accum * 10 + digit as two shifts and adds
	assign acc_wide = PROD_BITS'(accum);
	assign prod = (acc_wide << 3) + (acc_wide << 1) + PROD_BITS'(digit);

	// anything above the tag width is an overflow
	assign overflow   = |prod[PROD_BITS-1:TAG_BITS];
	assign accum_next = prod[TAG_BITS-1:0];

endmodule

// ===== sv/tvmp_step.sv =====
`timescale 1ns / 1ps

module tvmp_step import tvmp_pkg::*; #(
	parameter int unsigned TAG_BITS = 20
) (
	input  logic [TAG_BITS-1:0]       tag_cur,
	input  msg_state_t                st_cur,
	input  logic [BYTE_BITS-1:0]      data_byte,
	input  logic                      last,
	input  logic [BYTE_BITS-1:0]      field_delimiter,
	input  logic [FIELD_TAG_BITS-1:0] checksum_tag,
	output logic [TAG_BITS-1:0]       tag_next,
	output msg_state_t                st_next,
	output result_t                   res
);

	localparam int unsigned CMP_BITS = (TAG_BITS > FIELD_TAG_BITS) ? TAG_BITS : FIELD_TAG_BITS;
	localparam int unsigned CSAT_BITS = CHECK_BITS + 4;

	logic                  is_digit;
	logic [3:0]            digit;
	logic [TAG_BITS-1:0]   acc_next;
	logic                  acc_ovf;
	logic                  tag_is_check;
	logic [CMP_BITS-1:0]   tag_wide;
	logic [CSAT_BITS-1:0]  check_prod;
	logic [CHECK_BITS-1:0] check_sat;
	logic [TAG_BITS-1:0]   tag_next_pre;
	msg_state_t            st_mid;
	byte_kind_t            kind_mid;
	logic                  fend_mid;

	assign is_digit = data_byte inside {[DIGIT_ZERO:DIGIT_NINE]};
	assign digit    = is_digit ? 4'(data_byte - DIGIT_ZERO) : 4'd0;

	// decimal tag accumulate with overflow detect
	tvmp_tag_acc #(
		.TAG_BITS(TAG_BITS)
	) u_tag_acc (
		.accum      (tag_cur),
		.digit      (digit),
		.accum_next (acc_next),
		.overflow   (acc_ovf)
	);

	assign tag_is_check = (CMP_BITS'(tag_cur) == CMP_BITS'(checksum_tag));

	// checksum value accumulate, saturating
	assign check_prod = (CSAT_BITS'(st_cur.check_value_accum) << 3)
		+ (CSAT_BITS'(st_cur.check_value_accum) << 1) + CSAT_BITS'(digit);
	assign check_sat  = (check_prod > CSAT_BITS'(CHECK_MAX)) ? CHECK_MAX
		: check_prod[CHECK_BITS-1:0];

	assign tag_wide = CMP_BITS'(tag_next_pre);

	// byte classification and field state update
	always_comb begin
		st_mid       = st_cur;
		tag_next_pre = tag_cur;
		kind_mid     = KIND_TAG;
		fend_mid     = 1'b0;
		if (!st_cur.in_value) begin
			if (data_byte == SEP_BYTE) begin
				kind_mid        = KIND_SEP;
				st_mid.in_value = 1'b1;
				if (st_cur.tag_digit_seen && !st_cur.tag_overflow && tag_is_check) begin
					st_mid.check_field_active  = 1'b1;
					st_mid.check_value_accum   = '0;
					st_mid.check_digits_closed = 1'b0;
					st_mid.check_region_sum    = st_cur.field_start_sum;
				end
			end else begin
				kind_mid = KIND_TAG;
				if (!st_cur.tag_digits_closed) begin
					if (is_digit) begin
						if (!st_cur.tag_overflow) begin
							if (acc_ovf) begin
								st_mid.tag_overflow = 1'b1;
							end else begin
								tag_next_pre = acc_next;
							end
						end
						st_mid.tag_digit_seen = 1'b1;
					end else begin
						st_mid.tag_digits_closed = 1'b1;
					end
				end
			end
		end else if (data_byte == field_delimiter) begin
			kind_mid = KIND_DELIM;
			fend_mid = 1'b1;
		end else begin
			kind_mid = KIND_VALUE;
			if (st_cur.check_field_active && !st_cur.check_digits_closed) begin
				if (is_digit) begin
					st_mid.check_value_accum = check_sat;
				end else begin
					st_mid.check_digits_closed = 1'b1;
				end
			end
		end
		st_mid.running_sum = st_cur.running_sum + data_byte;
	end

	// field close, message close and result fields
	always_comb begin
		st_next       = st_mid;
		tag_next      = tag_next_pre;
		res.kind      = kind_mid;
		res.field_end = fend_mid;
		res.data      = data_byte;
		res.field_tag = tag_wide[FIELD_TAG_BITS-1:0];
		res.tag_ok    = st_mid.tag_digit_seen && !st_mid.tag_overflow;
		res.msg_end   = last;
		res.msg_ok    = 1'b0;
		if (kind_mid == KIND_DELIM) begin
			if (st_next.check_field_active) begin
				st_next.check_seen         = 1'b1;
				st_next.check_expected     = st_next.check_value_accum;
				st_next.check_field_active = 1'b0;
			end
			tag_next                  = '0;
			st_next.tag_digit_seen    = 1'b0;
			st_next.tag_digits_closed = 1'b0;
			st_next.tag_overflow      = 1'b0;
			st_next.in_value          = 1'b0;
			st_next.field_start_sum   = st_mid.running_sum;
		end
		if (last) begin
			// an open value field is closed by the end of the message
			if (st_next.in_value) begin
				res.field_end = 1'b1;
				if (st_next.check_field_active) begin
					st_next.check_seen         = 1'b1;
					st_next.check_expected     = st_next.check_value_accum;
					st_next.check_field_active = 1'b0;
				end
			end
			res.msg_ok = st_next.check_seen
				&& (CHECK_BITS'(st_next.check_region_sum) == st_next.check_expected);
			st_next  = '0;
			tag_next = '0;
		end
	end

endmodule

// ===== sv/tag_value_message_parser.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// --------+-----------+------------------------+-----------------------------------------
// in      | input     | in_valid / in_ready    | data_byte, last
// out     | output    | out_valid / out_ready  | byte_kind, data_out, field_tag, tag_ok,
//         |           |                        | field_end, msg_end, msg_ok
// cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// one byte per cycle sustained while the output is not stalled; a word reaches the
// outputs through the input register, then the step logic into the result register,
// and waits there for out_ready
// the parser state advances once per byte, when the input register moves on
// reset clears state, valid flags and the registers to SOH and tag 10
// a stalled output holds its word; the input register still takes one more byte

module tag_value_message_parser import tvmp_pkg::*; #(
	parameter int unsigned TAG_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [REG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [BYTE_BITS-1:0]      data_byte,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                byte_kind,
	output logic [BYTE_BITS-1:0]      data_out,
	output logic [FIELD_TAG_BITS-1:0] field_tag,
	output logic                      tag_ok,
	output logic                      field_end,
	output logic                      msg_end,
	output logic                      msg_ok
);

	logic [BYTE_BITS-1:0]      field_delimiter_q;
	logic [FIELD_TAG_BITS-1:0] checksum_tag_q;

	logic                 valid_s1;
	logic [BYTE_BITS-1:0] data_s1;
	logic                 last_s1;
	logic                 valid_s2;
	result_t              res_s2;

	logic [TAG_BITS-1:0] tag_q;
	msg_state_t          st_q;
	logic [TAG_BITS-1:0] tag_d;
	msg_state_t          st_d;
	result_t             res_d;

	logic advance;
	logic in_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_delimiter_q <= DELIM_RESET;
			checksum_tag_q    <= CHECKSUM_TAG_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FIELD_DELIM:  field_delimiter_q <= cfg_data[BYTE_BITS-1:0];
				REG_CHECKSUM_TAG: checksum_tag_q    <= cfg_data[FIELD_TAG_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// per-byte parse step
	tvmp_step #(
		.TAG_BITS(TAG_BITS)
	) u_step (
		.tag_cur         (tag_q),
		.st_cur          (st_q),
		.data_byte       (data_s1),
		.last            (last_s1),
		.field_delimiter (field_delimiter_q),
		.checksum_tag    (checksum_tag_q),
		.tag_next        (tag_d),
		.st_next         (st_d),
		.res             (res_d)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			st_q  <= '0;
		end else if (advance) begin
			tag_q <= tag_d;
			st_q  <= st_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = valid_s2;
	assign byte_kind = res_s2.kind;
	assign data_out  = res_s2.data;
	assign field_tag = res_s2.field_tag;
	assign tag_ok    = res_s2.tag_ok;
	assign field_end = res_s2.field_end;
	assign msg_end   = res_s2.msg_end;
	assign msg_ok    = res_s2.msg_ok;

endmodule

// ===== sv/tvmp_checker.sv =====
`timescale 1ns / 1ps

module tvmp_checker import tvmp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                byte_kind,
	input logic [BYTE_BITS-1:0]      data_out,
	input logic [FIELD_TAG_BITS-1:0] field_tag,
	input logic                      field_end,
	input logic                      msg_end,
	input logic                      msg_ok
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out)
			&& $stable(byte_kind) && $stable(field_tag))
		else $error("output word changed while stalled");

	// input only backs up behind a stalled output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back pressure");

	// checksum verdict only on the last byte
	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_ok |-> msg_end)
		else $error("msg_ok outside message end");

	// a field closes on the delimiter or at message end
	a_field_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_end |-> byte_kind == KIND_DELIM || msg_end)
		else $error("field_end on a non-delimiter byte");

	// a delimiter word always closes its field
	a_delim_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == KIND_DELIM |-> field_end)
		else $error("delimiter without field_end");

endmodule

bind tag_value_message_parser tvmp_checker u_tvmp_checker (.*);
